FILE: src/rmfh_pkg.sv
// rmfh_pkg: shared types and constants of the recursive mutex lock unit
// transaction structs, status codes, sequencer states and parameter defaults
// no dependencies
package rmfh_pkg;

  localparam int unsigned TaskW          = 4;
  localparam int unsigned TaskCountDef   = 16;
  localparam int unsigned QueueDepthDef  = 16;
  localparam int unsigned NestBitsDef    = 8;

  typedef enum logic [2:0] {
    STAT_GRANTED   = 3'd0,
    STAT_NESTED    = 3'd1,
    STAT_QUEUED    = 3'd2,
    STAT_UNNEST    = 3'd3,
    STAT_HANDOVER  = 3'd4,
    STAT_FREED     = 3'd5,
    STAT_NOT_OWNER = 3'd6,
    STAT_OVERFLOW  = 3'd7
  } status_e;

  typedef enum logic {
    ACT_OBTAIN  = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_EXEC = 1'b1
  } seq_state_e;

  typedef struct packed {
    logic             action;
    logic [TaskW-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             woken_valid;
    logic [TaskW-1:0] woken_task;
    logic             lock_owned;
    logic [TaskW-1:0] owner_task;
  } rsp_t;

endpackage

FILE: src/recursive_mutex_fifo_handoff.sv
// recursive_mutex_fifo_handoff: one recursive mutex with a fifo queue of waiting tasks
// a transaction accepted in idle is registered together with the wait queue head
// read, decided in the exec state and its result registered on rsp_o, marked by
// done_o; no new transaction is taken while busy_o is high during the decision
// reset frees the lock and empties the queue; no clearing pass, ready at once
// the receiver cannot stall, each result is marked by done_o for exactly one cycle
module recursive_mutex_fifo_handoff #(
  parameter int unsigned TASK_COUNT  = rmfh_pkg::TaskCountDef,
  parameter int unsigned QUEUE_DEPTH = rmfh_pkg::QueueDepthDef,
  parameter int unsigned NEST_BITS   = rmfh_pkg::NestBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rmfh_pkg::req_t req_i,
  output logic           done_o,
  output rmfh_pkg::rsp_t rsp_o
);
  import rmfh_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  seq_state_e state_q, state_d;

  req_t               req_q, req_d;
  logic               owned_q, owned_d;
  logic [TaskW-1:0]   owner_q, owner_d;
  logic [NEST_BITS-1:0] nest_q, nest_d;
  logic [PtrW-1:0]    head_q, head_d;
  logic [PtrW-1:0]    tail_q, tail_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic [TaskW-1:0]   wait_mem [QUEUE_DEPTH];
  logic [TaskW-1:0]   head_rd_q;
  logic               mem_we;
  logic               accept;
  logic [TaskW-1:0]   task_red;

  assign accept = start_i && (state_q == SEQ_IDLE);
  assign busy_o = (state_q == SEQ_EXEC);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // task number reduced modulo TASK_COUNT, a constant table over every task code
  always_comb begin
    task_red = '0;
    for (int i = 0; i < (1 << TaskW); i++) begin
      if (req_i.task_id == TaskW'(i)) begin
        task_red = TaskW'(i % TASK_COUNT);
      end
    end
  end

  // wait queue memory: head entry read on accept, tail written on enqueue
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wait_mem[tail_q] <= req_q.task_id;
    end
    if (accept) begin
      head_rd_q <= wait_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      owned_q <= 1'b0;
      owner_q <= '0;
      nest_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      owned_q <= owned_d;
      owner_q <= owner_d;
      nest_q  <= nest_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  always_comb begin
    logic [2:0] stat;
    logic       wk_valid;
    logic       full;

    state_d  = state_q;
    req_d    = req_q;
    owned_d  = owned_q;
    owner_d  = owner_q;
    nest_d   = nest_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    mem_we   = 1'b0;
    stat     = STAT_NOT_OWNER;
    wk_valid = 1'b0;
    full     = (count_q == CntW'(QUEUE_DEPTH));

    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          req_d.action  = req_i.action;
          req_d.task_id = task_red;
          state_d       = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (req_q.action == ACT_OBTAIN) begin
          if (!owned_q) begin
            owned_d = 1'b1;
            owner_d = req_q.task_id;
            nest_d  = '0;
            stat    = STAT_GRANTED;
          end else if (owner_q == req_q.task_id) begin
            if (&nest_q) begin
              stat = STAT_OVERFLOW;
            end else begin
              nest_d = nest_q + 1'b1;
              stat   = STAT_NESTED;
            end
          end else if (full) begin
            stat = STAT_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            tail_d  = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            count_d = count_q + 1'b1;
            stat    = STAT_QUEUED;
          end
        end else begin
          if (!owned_q || (owner_q != req_q.task_id)) begin
            stat = STAT_NOT_OWNER;
          end else if (nest_q != '0) begin
            nest_d = nest_q - 1'b1;
            stat   = STAT_UNNEST;
          end else if (count_q != '0) begin
            // hand the lock straight to the oldest waiter
            owner_d  = head_rd_q;
            head_d   = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d  = count_q - 1'b1;
            wk_valid = 1'b1;
            stat     = STAT_HANDOVER;
          end else begin
            owned_d = 1'b0;
            owner_d = '0;
            stat    = STAT_FREED;
          end
        end
        rsp_d.status      = stat;
        rsp_d.woken_valid = wk_valid;
        rsp_d.woken_task  = wk_valid ? head_rd_q : '0;
        rsp_d.lock_owned  = owned_d;
        rsp_d.owner_task  = owned_d ? owner_d : '0;
        done_d            = 1'b1;
        state_d           = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

endmodule
